FILE: hdl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants of the paging frame scheduler.
// ----------------------------------------------------------------------------
package pfs_pkg;

	localparam int ID_W    = 31;
	localparam int FRAME_W = 10;
	localparam int KIND_W  = 2;
	localparam int DIV_W   = 11;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_RECORD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MIB    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DROP   = 2'd3;

	// input functions
	localparam logic FUNC_REQUEST = 1'b0;
	localparam logic FUNC_TICK    = 1'b1;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_DRX   = 2'd0;
	localparam logic [1:0] REG_NPF   = 2'd1;
	localparam logic [1:0] REG_QCAP  = 2'd2;

	localparam logic [10:0] DRX_RESET  = 11'd32;
	localparam logic [10:0] NPF_RESET  = 11'd4;
	localparam logic [4:0]  QCAP_RESET = 5'd10;
	localparam int          MIB_BITS   = 3;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [17:0] {
		ST_CLEAR = 18'b000000000000000001,
		ST_IDLE  = 18'b000000000000000010,
		ST_L1    = 18'b000000000000000100,
		ST_W1    = 18'b000000000000001000,
		ST_L2    = 18'b000000000000010000,
		ST_W2    = 18'b000000000000100000,
		ST_L3    = 18'b000000000001000000,
		ST_W3    = 18'b000000000010000000,
		ST_MUL   = 18'b000000000100000000,
		ST_STEP  = 18'b000000001000000000,
		ST_RD    = 18'b000000010000000000,
		ST_CHK   = 18'b000000100000000000,
		ST_ROUT  = 18'b000001000000000000,
		ST_TRD   = 18'b000010000000000000,
		ST_TFILL = 18'b000100000000000000,
		ST_TREC  = 18'b001000000000000000,
		ST_TOUT  = 18'b010000000000000000,
		ST_TMIB  = 18'b100000000000000000
	} state_t;

endpackage

FILE: hdl/pfs_div.sv
// ----------------------------------------------------------------------------
// pfs_div
// Restoring divider, one quotient bit per cycle; quotient and remainder.
// ----------------------------------------------------------------------------
module pfs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pfs_pkg::div_req_t req,
	output pfs_pkg::div_rsp_t rsp
);

	localparam int W  = pfs_pkg::DIV_W;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dsr_q;
	logic [W-1:0]  rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    r_sh;
	logic          ge;

	always_comb begin
		r_sh = {rem_q, dvd_q[W-1]};
		ge   = r_sh >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? W'(r_sh - {1'b0, dsr_q}) : W'(r_sh);
			dvd_q <= {dvd_q[W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = dvd_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: hdl/pfs_store.sv
// ----------------------------------------------------------------------------
// pfs_store
// Frame fill counts and record store, synchronous read, registered data.
// ----------------------------------------------------------------------------
module pfs_store #(
	parameter int FRAMES      = 1024,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  fill_we,
	input  logic [$clog2(FRAMES)-1:0]             fill_waddr,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      fill_wdata,
	input  logic [$clog2(FRAMES)-1:0]             fill_raddr,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]      fill_rdata,
	input  logic                                  rec_we,
	input  logic [$clog2(FRAMES)+((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] rec_waddr,
	input  logic [pfs_pkg::ID_W-1:0]              rec_wdata,
	input  logic [$clog2(FRAMES)+((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] rec_raddr,
	output logic [pfs_pkg::ID_W-1:0]              rec_rdata
);

	localparam int FLW   = $clog2(QUEUE_DEPTH + 1);
	localparam int QIW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int RDEP  = FRAMES << QIW;

	logic [FLW-1:0]          fill_mem [FRAMES];
	logic [pfs_pkg::ID_W-1:0] rec_mem [RDEP];

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		fill_rdata <= fill_mem[fill_raddr];
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		rec_rdata <= rec_mem[rec_raddr];
	end

endmodule

FILE: hdl/paging_frame_scheduler_unit.sv
// ----------------------------------------------------------------------------
// paging_frame_scheduler_unit
// Paging frame scheduler over a system frame number wheel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, func, ue_id) takes one item per
//   transfer: a page request (func 0) or a frame tick (func 1).
//   Output channel (out_valid/out_stall, kind, frame_number, paged_id, last)
//   delivers results one transfer at a time; last marks the final result.
//   Items are handled one at a time. A request runs three divisions on the
//   shared divider, then probes the fill memory one candidate frame at a
//   time, up to FRAMES/drx candidates. A tick reads the current frame's
//   fill count, then sends each queued record and, on frames that are a
//   multiple of eight, the MIB marker; each result waits for an output transfer.
//   After reset the fill memory is swept to zero, one frame per cycle;
//   in_stall stays high meanwhile. APB writes are taken at any time. A
//   stalled receiver holds the output register and the sequencer waits;
//   a new item may be taken while a result is waiting.
// ----------------------------------------------------------------------------
module paging_frame_scheduler_unit #(
	parameter int FRAMES      = 1024,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic [pfs_pkg::ID_W-1:0]     ue_id,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pfs_pkg::KIND_W-1:0]   kind,
	output logic [pfs_pkg::FRAME_W-1:0]  frame_number,
	output logic [pfs_pkg::ID_W-1:0]     paged_id,
	output logic                         last,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pfs_pkg::APB_AW-1:0]   paddr,
	input  logic [pfs_pkg::APB_DW-1:0]   pwdata,
	output logic [pfs_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	localparam int FW  = $clog2(FRAMES);
	localparam int FLW = $clog2(QUEUE_DEPTH + 1);
	localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int RAW = FW + QIW;
	localparam int DW  = pfs_pkg::DIV_W;
	localparam int FNW = pfs_pkg::FRAME_W;

	// configuration registers
	logic [10:0] drx_q;
	logic [10:0] npf_q;
	logic [4:0]  qcap_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drx_q  <= pfs_pkg::DRX_RESET;
			npf_q  <= pfs_pkg::NPF_RESET;
			qcap_q <= pfs_pkg::QCAP_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				pfs_pkg::REG_DRX:  drx_q  <= pwdata[10:0];
				pfs_pkg::REG_NPF:  npf_q  <= pwdata[10:0];
				pfs_pkg::REG_QCAP: qcap_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pfs_pkg::REG_DRX:  prdata = 32'(drx_q);
			pfs_pkg::REG_NPF:  prdata = 32'(npf_q);
			pfs_pkg::REG_QCAP: prdata = 32'(qcap_q);
			default:           prdata = '0;
		endcase
	end

	// effective settings: zero drx or npf means one; drx and qcap saturate to the wheel and queue sizes
	logic [DW-1:0]  d_eff;
	logic [DW-1:0]  p_eff;
	logic [FLW-1:0] cap_eff;
	logic [6:0]     qcap_ext;

	always_comb begin
		if (drx_q == '0) begin
			d_eff = 11'd1;
		end else if (drx_q > 11'(FRAMES)) begin
			d_eff = 11'(FRAMES);
		end else begin
			d_eff = drx_q;
		end
		p_eff    = (npf_q == '0) ? 11'd1 : npf_q;
		qcap_ext = 7'(qcap_q);
		cap_eff  = (qcap_ext > 7'(QUEUE_DEPTH)) ? FLW'(QUEUE_DEPTH) : FLW'(qcap_ext);
	end

	// sequencer state
	pfs_pkg::state_t state_q;
	logic [FW-1:0]   clr_q;
	logic [FW-1:0]   cur_q;
	logic [FW-1:0]   f_q;
	logic [11:0]     acc_q;
	logic [DW-1:0]   quo_q;
	logic [DW-1:0]   modp_q;
	logic [DW-1:0]   c_q;
	logic [DW-1:0]   rem_q;
	logic [pfs_pkg::ID_W-1:0] req_id_q;
	logic [FLW-1:0]  n_q;
	logic [FLW-1:0]  idx_q;
	logic            mib_q;
	logic            res_drop_q;

	// output register
	logic                        ovalid_q;
	logic [pfs_pkg::KIND_W-1:0]  kind_q;
	logic [pfs_pkg::FRAME_W-1:0] frame_q;
	logic [pfs_pkg::ID_W-1:0]    pid_q;
	logic                        last_q;
	logic                        out_free;
	logic                        out_load;

	assign out_valid    = ovalid_q;
	assign kind         = kind_q;
	assign frame_number = frame_q;
	assign paged_id     = pid_q;
	assign last         = last_q;
	assign out_free     = !ovalid_q || !out_stall;
	// a result state loads the output register this cycle
	assign out_load     = out_free && (state_q == pfs_pkg::ST_ROUT
		|| state_q == pfs_pkg::ST_TOUT || state_q == pfs_pkg::ST_TMIB);

	assign in_stall = (state_q != pfs_pkg::ST_IDLE);

	logic in_take;
	assign in_take = in_valid && !in_stall;

	// divider
	pfs_pkg::div_req_t div_req;
	pfs_pkg::div_rsp_t div_rsp;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = d_eff;
		div_req.divisor  = p_eff;
		unique case (state_q)
			pfs_pkg::ST_L1: begin
				div_req.start = 1'b1;
			end
			pfs_pkg::ST_L2: begin
				div_req.start    = 1'b1;
				div_req.dividend = {1'b0, req_id_q[9:0]};
			end
			pfs_pkg::ST_L3: begin
				div_req.start    = 1'b1;
				div_req.dividend = DW'(cur_q);
				div_req.divisor  = d_eff;
			end
			default: ;
		endcase
	end

	pfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// storage
	logic           fill_we;
	logic [FW-1:0]  fill_waddr;
	logic [FLW-1:0] fill_wdata;
	logic [FW-1:0]  fill_raddr;
	logic [FLW-1:0] fill_rdata;
	logic           rec_we;
	logic [RAW-1:0] rec_waddr;
	logic [RAW-1:0] rec_raddr;
	logic [pfs_pkg::ID_W-1:0] rec_rdata;
	logic           has_room;

	assign has_room   = fill_rdata < cap_eff;
	assign fill_raddr = (state_q == pfs_pkg::ST_RD || state_q == pfs_pkg::ST_CHK) ? f_q : cur_q;
	assign rec_raddr  = {cur_q, idx_q[QIW-1:0]};
	assign rec_waddr  = {f_q, fill_rdata[QIW-1:0]};
	assign rec_we     = (state_q == pfs_pkg::ST_CHK) && has_room;

	always_comb begin
		fill_we    = 1'b0;
		fill_waddr = cur_q;
		fill_wdata = '0;
		unique case (state_q)
			pfs_pkg::ST_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_q;
			end
			pfs_pkg::ST_CHK: begin
				fill_we    = has_room;
				fill_waddr = f_q;
				fill_wdata = fill_rdata + 1'b1;
			end
			pfs_pkg::ST_TFILL: begin
				fill_we = 1'b1;
			end
			default: ;
		endcase
	end

	pfs_store #(
		.FRAMES      (FRAMES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk        (clk),
		.fill_we    (fill_we),
		.fill_waddr (fill_waddr),
		.fill_wdata (fill_wdata),
		.fill_raddr (fill_raddr),
		.fill_rdata (fill_rdata),
		.rec_we     (rec_we),
		.rec_waddr  (rec_waddr),
		.rec_wdata  (req_id_q),
		.rec_raddr  (rec_raddr),
		.rec_rdata  (rec_rdata)
	);

	// candidate frame arithmetic
	logic [11:0] step;
	logic [11:0] fsum0;
	logic [11:0] fsum1;
	logic [11:0] acc_n;
	logic        more;
	logic [FW-1:0] cur_inc;

	always_comb begin
		if (rem_q > c_q) begin
			step = 12'(rem_q) - 12'(c_q);
		end else if (rem_q == c_q) begin
			step = 12'(d_eff);
		end else begin
			step = 12'(d_eff) + 12'(rem_q) - 12'(c_q);
		end
		fsum0 = 12'(cur_q) + step;
		if (fsum0 >= 12'(FRAMES)) begin
			fsum0 = fsum0 - 12'(FRAMES);
		end
		fsum1 = 12'(f_q) + 12'(d_eff);
		if (fsum1 >= 12'(FRAMES)) begin
			fsum1 = fsum1 - 12'(FRAMES);
		end
		acc_n   = acc_q + 12'(d_eff);
		more    = (13'(acc_n) + 13'(d_eff)) <= 13'(FRAMES);
		cur_inc = (cur_q == FW'(FRAMES - 1)) ? '0 : cur_q + 1'b1;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pfs_pkg::ST_CLEAR;
			clr_q    <= '0;
			cur_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall && !out_load) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				pfs_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == FW'(FRAMES - 1)) begin
						state_q <= pfs_pkg::ST_IDLE;
					end
				end
				pfs_pkg::ST_IDLE: begin
					if (in_take) begin
						state_q <= (func == pfs_pkg::FUNC_TICK) ? pfs_pkg::ST_TRD
							: pfs_pkg::ST_L1;
					end
				end
				pfs_pkg::ST_L1:   state_q <= pfs_pkg::ST_W1;
				pfs_pkg::ST_W1:   if (div_rsp.done) state_q <= pfs_pkg::ST_L2;
				pfs_pkg::ST_L2:   state_q <= pfs_pkg::ST_W2;
				pfs_pkg::ST_W2:   if (div_rsp.done) state_q <= pfs_pkg::ST_L3;
				pfs_pkg::ST_L3:   state_q <= pfs_pkg::ST_W3;
				pfs_pkg::ST_W3:   if (div_rsp.done) state_q <= pfs_pkg::ST_MUL;
				pfs_pkg::ST_MUL:  state_q <= pfs_pkg::ST_STEP;
				pfs_pkg::ST_STEP: state_q <= pfs_pkg::ST_RD;
				pfs_pkg::ST_RD:   state_q <= pfs_pkg::ST_CHK;
				pfs_pkg::ST_CHK: begin
					// room: queue here; otherwise step to the next candidate frame or drop
					if (has_room || !more) begin
						state_q <= pfs_pkg::ST_ROUT;
					end else begin
						state_q <= pfs_pkg::ST_RD;
					end
				end
				pfs_pkg::ST_ROUT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						state_q  <= pfs_pkg::ST_IDLE;
					end
				end
				pfs_pkg::ST_TRD:  state_q <= pfs_pkg::ST_TFILL;
				pfs_pkg::ST_TFILL: begin
					if (fill_rdata != '0) begin
						state_q <= pfs_pkg::ST_TREC;
					end else if (cur_q[pfs_pkg::MIB_BITS-1:0] == '0) begin
						state_q <= pfs_pkg::ST_TMIB;
					end else begin
						cur_q   <= cur_inc;
						state_q <= pfs_pkg::ST_IDLE;
					end
				end
				pfs_pkg::ST_TREC: state_q <= pfs_pkg::ST_TOUT;
				pfs_pkg::ST_TOUT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						if (idx_q + 1'b1 != n_q) begin
							state_q <= pfs_pkg::ST_TREC;
						end else if (mib_q) begin
							state_q <= pfs_pkg::ST_TMIB;
						end else begin
							cur_q   <= cur_inc;
							state_q <= pfs_pkg::ST_IDLE;
						end
					end
				end
				pfs_pkg::ST_TMIB: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						cur_q    <= cur_inc;
						state_q  <= pfs_pkg::ST_IDLE;
					end
				end
				default: state_q <= pfs_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			pfs_pkg::ST_IDLE: begin
				req_id_q <= ue_id;
			end
			pfs_pkg::ST_W1: if (div_rsp.done) quo_q  <= div_rsp.quo;
			pfs_pkg::ST_W2: if (div_rsp.done) modp_q <= div_rsp.rem;
			pfs_pkg::ST_W3: if (div_rsp.done) c_q    <= div_rsp.rem;
			pfs_pkg::ST_MUL: begin
				rem_q <= DW'(quo_q * modp_q);
			end
			pfs_pkg::ST_STEP: begin
				f_q   <= FW'(fsum0);
				acc_q <= '0;
			end
			pfs_pkg::ST_CHK: begin
				res_drop_q <= !has_room;
				if (!has_room && more) begin
					f_q   <= FW'(fsum1);
					acc_q <= acc_n;
				end
			end
			pfs_pkg::ST_TFILL: begin
				n_q   <= fill_rdata;
				idx_q <= '0;
				mib_q <= (cur_q[pfs_pkg::MIB_BITS-1:0] == '0);
			end
			default: ;
		endcase

		if (state_q == pfs_pkg::ST_ROUT && out_free) begin
			kind_q  <= res_drop_q ? pfs_pkg::KIND_DROP : pfs_pkg::KIND_ACCEPT;
			frame_q <= res_drop_q ? '0 : FNW'(f_q);
			pid_q   <= req_id_q;
			last_q  <= 1'b1;
		end
		if (state_q == pfs_pkg::ST_TOUT && out_free) begin
			kind_q  <= pfs_pkg::KIND_RECORD;
			frame_q <= FNW'(cur_q);
			pid_q   <= rec_rdata;
			last_q  <= !mib_q && (idx_q + 1'b1 == n_q);
			idx_q   <= idx_q + 1'b1;
		end
		if (state_q == pfs_pkg::ST_TMIB && out_free) begin
			kind_q  <= pfs_pkg::KIND_MIB;
			frame_q <= FNW'(cur_q);
			pid_q   <= '0;
			last_q  <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == pfs_pkg::ST_W1 || state_q == pfs_pkg::ST_W2
			|| state_q == pfs_pkg::ST_W3))
		else $error("divider done outside a wait state");
	a_offset_below_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfs_pkg::ST_STEP) |-> (rem_q < d_eff))
		else $error("paging offset not below drx cycle");
	a_room_goes_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfs_pkg::ST_CHK && has_room) |=> (state_q == pfs_pkg::ST_ROUT))
		else $error("accepted request did not go to output");
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfs_pkg::ST_CLEAR) |-> (in_stall && !ovalid_q))
		else $error("activity during fill clear");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the paging frame scheduler.
// Page requests and frame ticks are sent through the valid/stall input,
// and every result transfer is checked against an in-bench model of the
// frame wheel: fill counts, per-frame record lists and the current frame.
// The bench steps through several register settings, the extremes among
// them, and idles both sides at random.
// ----------------------------------------------------------------------------
module tb;

	localparam int NFRAMES   = 1024;
	localparam int QDEPTH    = 16;
	localparam int WDOG_MAX  = 40000;
	localparam int SETTLE    = 120;
	localparam int ID_W      = pfs_pkg::ID_W;
	localparam int KIND_W    = pfs_pkg::KIND_W;
	localparam int FRAME_W   = pfs_pkg::FRAME_W;
	localparam int APB_AW    = pfs_pkg::APB_AW;
	localparam int APB_DW    = pfs_pkg::APB_DW;

	typedef struct {
		logic            fn;
		logic [ID_W-1:0] id;
	} page_item_t;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [FRAME_W-1:0] frame;
		logic [ID_W-1:0]    id;
		logic               last;
	} sched_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                func = pfs_pkg::FUNC_REQUEST;
	logic [ID_W-1:0]     ue_id = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [FRAME_W-1:0]  frame_number;
	logic [ID_W-1:0]     paged_id;
	logic                last;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	paging_frame_scheduler_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .ue_id(ue_id),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.frame_number(frame_number), .paged_id(paged_id), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---- wheel model -------------------------------------------------------
	int unsigned   drx_cfg = pfs_pkg::DRX_RESET;
	int unsigned   npf_cfg = pfs_pkg::NPF_RESET;
	int unsigned   cap_cfg = pfs_pkg::QCAP_RESET;
	int unsigned   cur_frame = 0;
	int unsigned   frame_fill [NFRAMES];
	logic [ID_W-1:0] frame_records [NFRAMES][QDEPTH];

	page_item_t    pending_items [$];
	sched_result_t expected_results [$];

	int errors = 0;
	int n_req = 0, n_tick = 0, n_accept = 0, n_drop = 0, n_rec = 0, n_mib = 0;
	bit calm = 1'b0;
	int idle_cnt = 0;

	initial foreach (frame_fill[i]) frame_fill[i] = 0;

	function automatic void push_result(logic [KIND_W-1:0] k, int unsigned f,
	                                    logic [ID_W-1:0] id, bit l);
		sched_result_t r;
		r.kind = k;
		r.frame = f[FRAME_W-1:0];
		r.id = id;
		r.last = l;
		expected_results.push_back(r);
	endfunction

	// Place one request on the wheel and queue the answer it gets.
	function automatic void schedule_page(logic [ID_W-1:0] id);
		int unsigned d, p, cap, offs, c, step, tries, f;
		d = (drx_cfg == 0) ? 1 : (drx_cfg > NFRAMES ? NFRAMES : drx_cfg);
		p = (npf_cfg == 0) ? 1 : npf_cfg;
		cap = (cap_cfg > QDEPTH) ? QDEPTH : cap_cfg;
		offs = (d / p) * ((id % 1024) % p);
		c = cur_frame % d;
		if (offs > c)
			step = offs - c;
		else if (offs == c)
			step = d;
		else
			step = d + offs - c;
		tries = NFRAMES / d;
		for (int k = 0; k < tries; k++) begin
			f = (cur_frame + step + k * d) % NFRAMES;
			if (frame_fill[f] < cap) begin
				frame_records[f][frame_fill[f]] = id;
				frame_fill[f]++;
				push_result(pfs_pkg::KIND_ACCEPT, f, id, 1'b1);
				return;
			end
		end
		push_result(pfs_pkg::KIND_DROP, 0, id, 1'b1);
	endfunction

	// Flush the current frame's queue, add the MIB marker on every eighth frame, advance.
	function automatic void broadcast_frame();
		int unsigned f, n;
		bit mib;
		f = cur_frame;
		n = frame_fill[f];
		mib = (f % 8) == 0;
		for (int i = 0; i < n; i++)
			push_result(pfs_pkg::KIND_RECORD, f, frame_records[f][i], !mib && i + 1 == n);
		frame_fill[f] = 0;
		if (mib)
			push_result(pfs_pkg::KIND_MIB, f, '0, 1'b1);
		cur_frame = (f + 1) % NFRAMES;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch on %s: got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	// ---- input driver ------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (func == pfs_pkg::FUNC_REQUEST) begin
					n_req++;
					schedule_page(ue_id);
				end else begin
					n_tick++;
					broadcast_frame();
				end
			end
			if (!(in_valid && in_stall)) begin
				if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
					page_item_t it;
					it = pending_items.pop_front();
					in_valid <= 1'b1;
					func <= it.fn;
					ue_id <= it.id;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---- result monitor ----------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sched_result_t w;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected transfer kind", kind, 0);
				end else begin
					w = expected_results.pop_front();
					if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
					if (frame_number !== w.frame)
						report_mismatch("frame_number", frame_number, w.frame);
					if (paged_id !== w.id) report_mismatch("paged_id", paged_id, w.id);
					if (last !== w.last) report_mismatch("last", last, w.last);
					case (kind)
						pfs_pkg::KIND_RECORD: n_rec++;
						pfs_pkg::KIND_MIB:    n_mib++;
						pfs_pkg::KIND_ACCEPT: n_accept++;
						default:              n_drop++;
					endcase
				end
			end
			out_stall <= !calm && ($urandom_range(99) < 22);
		end
	end

	// ---- watchdog: count cycles with no transfer on either side ------------
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_MAX) begin
			$display("watchdog expired with %0d results outstanding",
			         expected_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---- register access ---------------------------------------------------
	task automatic write_reg(logic [1:0] idx, int unsigned value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// register takes the value at this edge
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			pfs_pkg::REG_DRX:  drx_cfg = value & 11'h7FF;
			pfs_pkg::REG_NPF:  npf_cfg = value & 11'h7FF;
			pfs_pkg::REG_QCAP: cap_cfg = value & 5'h1F;
			default: ;
		endcase
	endtask

	// Hold until the block is drained, then let trailing ticks settle.
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reconfigure(int unsigned d, int unsigned p, int unsigned q);
		drain();
		write_reg(pfs_pkg::REG_DRX, d);
		write_reg(pfs_pkg::REG_NPF, p);
		write_reg(pfs_pkg::REG_QCAP, q);
	endtask

	task automatic add_item(logic fn, logic [ID_W-1:0] id);
		page_item_t it;
		it.fn = fn;
		it.id = id;
		pending_items.push_back(it);
	endtask

	// Mostly requests with random ids, plus runs of ticks so queues drain.
	task automatic add_random(int cnt);
		for (int i = 0; i < cnt; i++) begin
			if ($urandom_range(99) < 12) begin
				repeat ($urandom_range(8, 2)) add_item(pfs_pkg::FUNC_TICK, ID_W'($urandom));
			end else if ($urandom_range(99) < 40) begin
				add_item(pfs_pkg::FUNC_TICK, ID_W'($urandom));
			end else begin
				add_item(pfs_pkg::FUNC_REQUEST, ID_W'($urandom));
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, id extremes, MIB frame
		add_item(pfs_pkg::FUNC_REQUEST, '0);
		add_item(pfs_pkg::FUNC_REQUEST, {ID_W{1'b1}});
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(3));
		add_item(pfs_pkg::FUNC_TICK, '0);
		add_item(pfs_pkg::FUNC_TICK, {ID_W{1'b1}});

		// a single candidate frame per id and capacity 1: second same-offset request drops
		reconfigure(1024, 1024, 1);
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(5));
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(1024 + 5));
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(1));
		add_item(pfs_pkg::FUNC_TICK, '0);
		add_item(pfs_pkg::FUNC_TICK, '0);

		// zero capacity drops everything
		reconfigure(32, 4, 0);
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(77));
		add_item(pfs_pkg::FUNC_TICK, '0);

		// zero drx and zero paging frames, oversized capacity
		reconfigure(0, 0, 31);
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(9));
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(10));
		add_item(pfs_pkg::FUNC_TICK, '0);
		add_item(pfs_pkg::FUNC_TICK, '0);

		// oversized drx and paging frames
		reconfigure(2047, 2047, 16);
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(1000));
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(3));

		// paging frames above drx: offset 0; then drx not dividing the wheel
		reconfigure(8, 100, 2);
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(123));
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(456));
		reconfigure(24, 3, 4);
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(2));
		add_item(pfs_pkg::FUNC_REQUEST, ID_W'(4));
		add_item(pfs_pkg::FUNC_TICK, '0);

		// random phases over a spread of settings
		reconfigure(4, 2, 3);
		add_random(12);
		reconfigure(16, 4, 2);
		add_random(12);
		reconfigure(1, 1, 16);
		add_random(9);
		// lower capacity below filled frames
		reconfigure(16, 16, 1);
		add_random(9);
		calm = 1'b1;
		reconfigure(32, 4, 10);
		add_random(10);
		drain();
		calm = 1'b0;

		$display("requests %0d ticks %0d: accepted %0d dropped %0d", n_req, n_tick,
		         n_accept, n_drop);
		$display("paging records %0d, MIB markers %0d, mismatches %0d", n_rec, n_mib,
		         errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
hdl/pfs_pkg.sv
hdl/pfs_div.sv
hdl/pfs_store.sv
hdl/paging_frame_scheduler_unit.sv
tb/tb.sv
